/* src/texture_sampler_nearest_bilinear_assert.svh */
`ifndef TEXTURE_SAMPLER_NEAREST_BILINEAR_ASSERT_SVH
`define TEXTURE_SAMPLER_NEAREST_BILINEAR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TSNB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsnb same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TSNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsnb next-cycle check failed");

`endif

/* src/tsnb_pkg.sv */
package tsnb_pkg;

	localparam int DIM_BITS   = 9;
	localparam int COORD_BITS = 16;
	localparam int ADDR_BITS  = 16;
	localparam int CH_BITS    = 8;
	localparam int NUM_CH     = 3;
	localparam int TEXEL_BITS = NUM_CH * CH_BITS;
	localparam int MEM_DEPTH  = 1 << ADDR_BITS;

	// integer part of a coordinate product, with sign
	localparam int POS_W = DIM_BITS + 1;
	localparam int EXT_W = DIM_BITS + 2;

	localparam int NUM_TAPS = 4;
	localparam int TAP_BITS = 2;
	localparam logic [TAP_BITS-1:0] TAP_LAST_NEAREST  = 2'd0;
	localparam logic [TAP_BITS-1:0] TAP_LAST_BILINEAR = 2'd3;

	// result queue and the credit count that keeps it from overflowing
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = 2;
	localparam int CNT_BITS   = 3;

	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int WEIGHT_BITS_DEF = 8;

	// 0.5 in unsigned 0.16
	localparam logic [COORD_BITS-1:0] HALF_COORD = 16'h8000;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam int APB_DATA_BITS = 32;
	localparam int PADDR_BITS    = 4;
	localparam int REG_IDX_BITS  = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_TEX_HEIGHT = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_BILINEAR   = 2'd2;

	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
	} texel_t;

	typedef struct packed {
		logic write;
		logic bil;
	} req_ctl_t;

	typedef struct packed {
		logic first;
		logic last;
	} tap_tag_t;

	// clamp a signed position into 0..dim-1
	function automatic logic [DIM_BITS-1:0] clamp_dim(
		input logic signed [EXT_W-1:0] p,
		input logic [DIM_BITS-1:0] dim
	);
		logic signed [EXT_W-1:0] top;
		top = signed'(EXT_W'(dim - DIM_BITS'(1)));
		if (p[EXT_W-1]) begin
			clamp_dim = '0;
		end else if (p > top) begin
			clamp_dim = dim - DIM_BITS'(1);
		end else begin
			clamp_dim = p[DIM_BITS-1:0];
		end
	endfunction

endpackage

/* src/texture_sampler_nearest_bilinear.sv */
// Channel     | Dir | Handshake                  | Payload
// s_axis      | in  | s_axis_tvalid/tready       | tdata: addr, rgb, u, v; tuser: cmd
// m_axis      | out | m_axis_tvalid/tready       | tdata: red, green, blue
// apb         | in  | psel, penable, pready      | paddr, pwdata, prdata
//
// Writes and nearest samples: one request per cycle unless the result queue is full.
// Bilinear samples: four taps each, one texel read per cycle through the single port
// of the texel memory. A request passes address stages s1 to s4, the sequencer's
// request register, the read stage s5 and the blend stage s6 into the result queue.
// Reset clears the pipeline and result queue; texel memory contents are undefined
// until written, and there is no clearing pass.
// m_axis_tready low fills a four-entry result queue, then reads stop and the
// input backs up through the address pipeline.
module texture_sampler_nearest_bilinear #(
	parameter int MAX_WIDTH   = tsnb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = tsnb_pkg::MAX_HEIGHT_DEF,
	parameter int WEIGHT_BITS = tsnb_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [15:0] texel_addr, [23:16] in_red, [31:24] in_green, [39:32] in_blue,
	// [55:40] coord_u, [71:56] coord_v
	input  logic [71:0] s_axis_tdata,
	// [0] cmd
	input  logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] out_red, [15:8] out_green, [23:16] out_blue
	output logic [23:0] m_axis_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tsnb_pkg::PADDR_BITS-1:0] paddr,
	input  logic [tsnb_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [tsnb_pkg::APB_DATA_BITS-1:0] prdata,
	output logic pready
);
	import tsnb_pkg::*;

	localparam int WT_W = 2 * WEIGHT_BITS + 1;

	// Configuration registers
	logic [DIM_BITS-1:0] tex_width_q, tex_height_q;
	logic bilinear_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_BITS-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= DIM_BITS'(256);
			tex_height_q <= DIM_BITS'(256);
			bilinear_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TEX_WIDTH:  tex_width_q  <= pwdata[DIM_BITS-1:0];
				REG_TEX_HEIGHT: tex_height_q <= pwdata[DIM_BITS-1:0];
				REG_BILINEAR:   bilinear_q   <= pwdata[0];
				default: ;  // drop writes to unmapped addresses
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TEX_WIDTH:  prdata = APB_DATA_BITS'(tex_width_q);
			REG_TEX_HEIGHT: prdata = APB_DATA_BITS'(tex_height_q);
			REG_BILINEAR:   prdata = APB_DATA_BITS'(bilinear_q);
			default:        prdata = '0;
		endcase
	end

	// Unpack the input request
	texel_t in_texel;
	assign in_texel.red   = s_axis_tdata[23:16];
	assign in_texel.green = s_axis_tdata[31:24];
	assign in_texel.blue  = s_axis_tdata[39:32];

	// Address generation: products, clamps, linear addresses, weights
	logic ag_valid, ag_ready;
	req_ctl_t ag_ctl;
	logic [NUM_TAPS-1:0][ADDR_BITS-1:0] ag_addr;
	logic [NUM_TAPS-1:0][WT_W-1:0] ag_wt;
	texel_t ag_texel;

	tsnb_addr_gen #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_addr_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (s_axis_tuser[0]),
		.in_addr    (s_axis_tdata[15:0]),
		.in_texel   (in_texel),
		.in_u       (s_axis_tdata[55:40]),
		.in_v       (s_axis_tdata[71:56]),
		.tex_width  (tex_width_q),
		.tex_height (tex_height_q),
		.bilinear   (bilinear_q),
		.out_valid  (ag_valid),
		.out_ready  (ag_ready),
		.out_ctl    (ag_ctl),
		.out_addr   (ag_addr),
		.out_wt     (ag_wt),
		.out_texel  (ag_texel)
	);

	// Texel memory and the sequencer that walks the taps of each sample
	logic rd_valid;
	tap_tag_t rd_tag;
	logic [WT_W-1:0] rd_wt;
	texel_t rd_texel;
	logic out_pop;

	assign out_pop = m_axis_tvalid && m_axis_tready;

	tsnb_mem_seq #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_mem_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (ag_valid),
		.req_ready (ag_ready),
		.req_ctl   (ag_ctl),
		.req_addr  (ag_addr),
		.req_wt    (ag_wt),
		.req_texel (ag_texel),
		.out_pop   (out_pop),
		.rd_valid  (rd_valid),
		.rd_tag    (rd_tag),
		.rd_wt     (rd_wt),
		.rd_texel  (rd_texel)
	);

	// Weighted accumulation and result queue
	texel_t out_texel;

	tsnb_blend #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (rd_valid),
		.rd_tag    (rd_tag),
		.rd_wt     (rd_wt),
		.rd_texel  (rd_texel),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_texel (out_texel)
	);

	assign m_axis_tdata = {out_texel.blue, out_texel.green, out_texel.red};

endmodule

/* src/tsnb_addr_gen.sv */
module tsnb_addr_gen #(
	parameter int MAX_WIDTH   = tsnb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = tsnb_pkg::MAX_HEIGHT_DEF,
	parameter int WEIGHT_BITS = tsnb_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_cmd,
	input  logic [tsnb_pkg::ADDR_BITS-1:0] in_addr,
	input  tsnb_pkg::texel_t in_texel,
	input  logic [tsnb_pkg::COORD_BITS-1:0] in_u,
	input  logic [tsnb_pkg::COORD_BITS-1:0] in_v,
	input  logic [tsnb_pkg::DIM_BITS-1:0] tex_width,
	input  logic [tsnb_pkg::DIM_BITS-1:0] tex_height,
	input  logic bilinear,
	output logic out_valid,
	input  logic out_ready,
	output tsnb_pkg::req_ctl_t out_ctl,
	output logic [tsnb_pkg::NUM_TAPS-1:0][tsnb_pkg::ADDR_BITS-1:0] out_addr,
	output logic [tsnb_pkg::NUM_TAPS-1:0][2*WEIGHT_BITS:0] out_wt,
	output tsnb_pkg::texel_t out_texel
);
	import tsnb_pkg::*;

	localparam int WT_W   = 2 * WEIGHT_BITS + 1;
	localparam int PROD_W = COORD_BITS + DIM_BITS;
	localparam int DX_W   = PROD_W + 1;
	localparam int SUM_W  = 2 * DIM_BITS + 1;
	localparam logic [WEIGHT_BITS:0] ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

	function automatic logic [ADDR_BITS-1:0] lin_addr(
		input logic [2*DIM_BITS-1:0] rw,
		input logic signed [POS_W-1:0] c
	);
		logic signed [SUM_W-1:0] s;
		s = signed'({1'b0, rw}) + SUM_W'(c);
		lin_addr = s[SUM_W-1] ? '0 : s[ADDR_BITS-1:0];
	endfunction

	logic [DIM_BITS-1:0] w, h;

	always_comb begin
		if (tex_width == '0) begin
			w = DIM_BITS'(1);
		end else if (32'(tex_width) > MAX_WIDTH) begin
			w = DIM_BITS'(MAX_WIDTH);
		end else begin
			w = tex_width;
		end
		if (tex_height == '0) begin
			h = DIM_BITS'(1);
		end else if (32'(tex_height) > MAX_HEIGHT) begin
			h = DIM_BITS'(MAX_HEIGHT);
		end else begin
			h = tex_height;
		end
	end

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1: captured request
	logic cmd_s1, bil_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	texel_t texel_s1;
	logic [COORD_BITS-1:0] u_s1, v_s1;

	// stage 2: coordinate times size
	logic cmd_s2, bil_s2;
	logic [ADDR_BITS-1:0] addr_s2;
	texel_t texel_s2;
	logic [PROD_W-1:0] pu_s2, pv_s2;

	// stage 3: clamped columns and rows, fractions
	logic cmd_s3, bil_s3;
	logic [ADDR_BITS-1:0] addr_s3;
	texel_t texel_s3;
	logic [DIM_BITS-1:0] r0_s3, r1_s3;
	logic signed [POS_W-1:0] c0_s3, c1_s3;
	logic [WEIGHT_BITS-1:0] fx_s3, fy_s3;

	// stage 4: linear addresses and weights
	logic cmd_s4, bil_s4;
	logic [NUM_TAPS-1:0][ADDR_BITS-1:0] addr_s4;
	logic [NUM_TAPS-1:0][WT_W-1:0] wt_s4;
	texel_t texel_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 3 arithmetic
	logic [DX_W-1:0] dx, dy;
	logic signed [POS_W-1:0] x0, y0;
	logic signed [EXT_W-1:0] x1, y1;
	logic [DIM_BITS-1:0] cl_c0, cl_c1, cl_r0, cl_r1, nrow;
	logic signed [POS_W-1:0] ncol;

	always_comb begin
		dx = {1'b0, pu_s2} - DX_W'(HALF_COORD);
		dy = {1'b0, pv_s2} - DX_W'(HALF_COORD);
		x0 = signed'(dx[DX_W-1:COORD_BITS]);
		y0 = signed'(dy[DX_W-1:COORD_BITS]);
		x1 = EXT_W'(x0) + EXT_W'(1);
		y1 = EXT_W'(y0) + EXT_W'(1);
		cl_c0 = clamp_dim(EXT_W'(x0), w);
		cl_c1 = clamp_dim(x1, w);
		cl_r0 = h - DIM_BITS'(1) - clamp_dim(EXT_W'(y0), h);
		cl_r1 = h - DIM_BITS'(1) - clamp_dim(y1, h);
		// a zero product rounds down to the column left of the image
		ncol = (pu_s2 == '0) ? '1 : signed'({1'b0, pu_s2[PROD_W-1:COORD_BITS]});
		nrow = h - DIM_BITS'(1) - pv_s2[PROD_W-1:COORD_BITS];
	end

	// stage 4 arithmetic
	logic [2*DIM_BITS-1:0] rw0, rw1;
	logic [WEIGHT_BITS:0] wx0, wx1, wy0, wy1;
	logic [2*WEIGHT_BITS+1:0] pw0, pw1, pw2, pw3;

	always_comb begin
		rw0 = r0_s3 * w;
		rw1 = r1_s3 * w;
		wx0 = ONE - {1'b0, fx_s3};
		wx1 = {1'b0, fx_s3};
		wy0 = ONE - {1'b0, fy_s3};
		wy1 = {1'b0, fy_s3};
		pw0 = wx0 * wy0;
		pw1 = wx1 * wy0;
		pw2 = wx0 * wy1;
		pw3 = wx1 * wy1;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			cmd_s1   <= in_cmd;
			bil_s1   <= bilinear;
			addr_s1  <= in_addr;
			texel_s1 <= in_texel;
			u_s1     <= in_u;
			v_s1     <= in_v;
		end
		if (ready_s2 && valid_s1) begin
			cmd_s2   <= cmd_s1;
			bil_s2   <= bil_s1;
			addr_s2  <= addr_s1;
			texel_s2 <= texel_s1;
			pu_s2    <= u_s1 * w;
			pv_s2    <= v_s1 * h;
		end
		if (ready_s3 && valid_s2) begin
			cmd_s3   <= cmd_s2;
			bil_s3   <= bil_s2;
			addr_s3  <= addr_s2;
			texel_s3 <= texel_s2;
			if (bil_s2) begin
				r0_s3 <= cl_r0;
				r1_s3 <= cl_r1;
				c0_s3 <= signed'({1'b0, cl_c0});
				c1_s3 <= signed'({1'b0, cl_c1});
				fx_s3 <= dx[COORD_BITS-1 -: WEIGHT_BITS];
				fy_s3 <= dy[COORD_BITS-1 -: WEIGHT_BITS];
			end else begin
				// nearest: single tap, full weight
				r0_s3 <= nrow;
				r1_s3 <= nrow;
				c0_s3 <= ncol;
				c1_s3 <= ncol;
				fx_s3 <= '0;
				fy_s3 <= '0;
			end
		end
		if (ready_s4 && valid_s3) begin
			cmd_s4   <= cmd_s3;
			bil_s4   <= bil_s3;
			texel_s4 <= texel_s3;
			addr_s4[0] <= (cmd_s3 == CMD_WRITE) ? addr_s3 : lin_addr(rw0, c0_s3);
			addr_s4[1] <= lin_addr(rw0, c1_s3);
			addr_s4[2] <= lin_addr(rw1, c0_s3);
			addr_s4[3] <= lin_addr(rw1, c1_s3);
			wt_s4[0] <= pw0[WT_W-1:0];
			wt_s4[1] <= pw1[WT_W-1:0];
			wt_s4[2] <= pw2[WT_W-1:0];
			wt_s4[3] <= pw3[WT_W-1:0];
		end
	end

	assign out_valid     = valid_s4;
	assign out_ctl.write = (cmd_s4 == CMD_WRITE);
	assign out_ctl.bil   = bil_s4;
	assign out_addr      = addr_s4;
	assign out_wt        = wt_s4;
	assign out_texel     = texel_s4;

endmodule

/* src/tsnb_mem_seq.sv */
module tsnb_mem_seq #(
	parameter int WEIGHT_BITS = tsnb_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  tsnb_pkg::req_ctl_t req_ctl,
	input  logic [tsnb_pkg::NUM_TAPS-1:0][tsnb_pkg::ADDR_BITS-1:0] req_addr,
	input  logic [tsnb_pkg::NUM_TAPS-1:0][2*WEIGHT_BITS:0] req_wt,
	input  tsnb_pkg::texel_t req_texel,
	input  logic out_pop,
	output logic rd_valid,
	output tsnb_pkg::tap_tag_t rd_tag,
	output logic [2*WEIGHT_BITS:0] rd_wt,
	output tsnb_pkg::texel_t rd_texel
);
	import tsnb_pkg::*;

	localparam int WT_W = 2 * WEIGHT_BITS + 1;

	texel_t mem [MEM_DEPTH];

	logic busy_q;
	req_ctl_t ctl_q;
	logic [NUM_TAPS-1:0][ADDR_BITS-1:0] addr_q;
	logic [NUM_TAPS-1:0][WT_W-1:0] wt_q;
	texel_t texel_q;
	logic [TAP_BITS-1:0] tap_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic [TAP_BITS-1:0] last_tap;
	logic is_write, rd_go, start, done;

	logic valid_s5;
	tap_tag_t tag_s5;
	logic [WT_W-1:0] wt_s5;
	texel_t rdata_s5;

	always_comb begin
		last_tap = ctl_q.bil ? TAP_LAST_BILINEAR : TAP_LAST_NEAREST;
		is_write = busy_q && ctl_q.write;
		// a sample starts only with room reserved in the result queue
		rd_go    = busy_q && !ctl_q.write && (tap_q != '0 || cnt_q < CNT_BITS'(FIFO_DEPTH));
		start    = rd_go && (tap_q == '0);
		done     = is_write || (rd_go && tap_q == last_tap);
	end

	assign req_ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			tap_q    <= '0;
			cnt_q    <= '0;
			valid_s5 <= 1'b0;
		end else begin
			if (req_ready) begin
				busy_q <= req_valid;
				tap_q  <= '0;
			end else if (rd_go) begin
				tap_q <= tap_q + TAP_BITS'(1);
			end
			if (start && !out_pop) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (!start && out_pop) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
			valid_s5 <= rd_go;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			ctl_q   <= req_ctl;
			addr_q  <= req_addr;
			wt_q    <= req_wt;
			texel_q <= req_texel;
		end
		tag_s5.first <= start;
		tag_s5.last  <= (tap_q == last_tap);
		wt_s5        <= wt_q[tap_q];
	end

	// single port: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (is_write) begin
			mem[addr_q[0]] <= texel_q;
		end else begin
			rdata_s5 <= mem[addr_q[tap_q]];
		end
	end

	assign rd_valid = valid_s5;
	assign rd_tag   = tag_s5;
	assign rd_wt    = wt_s5;
	assign rd_texel = rdata_s5;

`include "texture_sampler_nearest_bilinear_assert.svh"

	`TSNB_ASSERT_SAME(a_credit_bound, clk, arst_n, 1'b1, cnt_q <= CNT_BITS'(FIFO_DEPTH))
	`TSNB_ASSERT_SAME(a_tap_mode, clk, arst_n, tap_q != '0, busy_q && ctl_q.bil && !ctl_q.write)
	`TSNB_ASSERT_NEXT(a_last_tap_frees, clk, arst_n, rd_go && tap_q == last_tap, tap_q == '0)

endmodule

/* src/tsnb_blend.sv */
module tsnb_blend #(
	parameter int WEIGHT_BITS = tsnb_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_valid,
	input  tsnb_pkg::tap_tag_t rd_tag,
	input  logic [2*WEIGHT_BITS:0] rd_wt,
	input  tsnb_pkg::texel_t rd_texel,
	output logic out_valid,
	input  logic out_ready,
	output tsnb_pkg::texel_t out_texel
);
	import tsnb_pkg::*;

	localparam int WT_W   = 2 * WEIGHT_BITS + 1;
	localparam int PROD_W = CH_BITS + WT_W;
	localparam int ACC_W  = 2 * WEIGHT_BITS + CH_BITS;
	localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (2 * WEIGHT_BITS - 1);

	logic [NUM_CH-1:0][CH_BITS-1:0] ch_in;
	logic [NUM_CH-1:0][PROD_W-1:0] prod;
	logic [NUM_CH-1:0][ACC_W-1:0] acc_next;
	logic [NUM_CH-1:0][CH_BITS-1:0] result;

	logic valid_s6;
	tap_tag_t tag_s6;
	logic [NUM_CH-1:0][ACC_W-1:0] prod_s6;
	logic [NUM_CH-1:0][ACC_W-1:0] acc_q;

	texel_t fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic push, pop;

	assign ch_in = rd_texel;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c] = ch_in[c] * rd_wt;
			// rounding constant rides in with the first tap
			acc_next[c] = tag_s6.first ? (prod_s6[c] + ROUND) : (acc_q[c] + prod_s6[c]);
			result[c] = acc_next[c][ACC_W-1 -: CH_BITS];
		end
	end

	assign push      = valid_s6 && tag_s6.last;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_texel = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			valid_s6 <= rd_valid;
			if (push) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (!push && pop) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s6 <= rd_tag;
		for (int c = 0; c < NUM_CH; c++) begin
			prod_s6[c] <= prod[c][ACC_W-1:0];
		end
		if (valid_s6) acc_q <= acc_next;
		if (push) fifo_q[wr_ptr_q] <= result;
	end

`include "texture_sampler_nearest_bilinear_assert.svh"

	`TSNB_ASSERT_SAME(a_no_overflow, clk, arst_n, push, count_q < CNT_BITS'(FIFO_DEPTH) || pop)
	`TSNB_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_BITS'(FIFO_DEPTH))
	`TSNB_ASSERT_NEXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule
